[hdl/matrix3_inverse_assert.svh]
// Assertion macros for the matrix3_inverse block.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define M3INV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("m3inv: same-cycle check failed");
`define M3INV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("m3inv: next-cycle check failed");
`else
`define M3INV_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define M3INV_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/m3inv_pkg.sv]
// Types and constants shared by the 3x3 matrix inverse block.
// No dependencies.
package m3inv_pkg;

    localparam int ELEM_W  = 32;
    localparam int N_ELEM  = 9;
    localparam int THR_W   = 31;
    localparam int COF_W   = 65;
    localparam int PP_W    = 65;
    localparam int PJ_W    = 97;
    localparam int DET_W   = 99;
    localparam int Q_BITS  = 33;
    localparam int DIV_LAT = Q_BITS + 2;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef t_elem t_mat [N_ELEM];
    typedef logic signed [COF_W-1:0] t_cof;
    typedef logic signed [PP_W-1:0] t_pp;
    typedef logic signed [PJ_W-1:0] t_pj;
    typedef logic signed [DET_W-1:0] t_det;

    localparam logic [Q_BITS-1:0] POS_LIM = Q_BITS'(33'h0_7FFF_FFFF);
    localparam logic [Q_BITS-1:0] NEG_LIM = Q_BITS'(33'h0_8000_0000);
    localparam t_elem SAT_POS = 32'sh7FFF_FFFF;
    localparam t_elem SAT_NEG = 32'sh8000_0000;

endpackage

[hdl/m3inv_div.sv]
// Nine-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage, sign fixup and saturation to 32 bits. Uses m3inv_pkg.
module m3inv_div #(
    parameter int NUM_W = 97
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [NUM_W-1:0]                    i_num [m3inv_pkg::N_ELEM],
    input  logic [m3inv_pkg::N_ELEM-1:0]        i_neg,
    input  logic [m3inv_pkg::DET_W-1:0]         i_den,
    output logic                                o_valid,
    output m3inv_pkg::t_mat                     o_quo,
    output logic                                o_ovf
);
    import m3inv_pkg::*;

    logic [Q_BITS:0]       r_vld;
    logic [DET_W-1:0]      r_den [Q_BITS+1];
    logic [N_ELEM-1:0]     r_pre [Q_BITS+1];
    logic [N_ELEM-1:0]     r_neg [Q_BITS+1];
    logic [DET_W-1:0]      r_rem [N_ELEM][Q_BITS+1];
    logic [Q_BITS-1:0]     r_low [N_ELEM][Q_BITS+1];
    logic [Q_BITS-1:0]     r_q   [N_ELEM][Q_BITS+1];
    logic [DET_W:0]        w_t   [N_ELEM][Q_BITS+1];
    logic                  w_ge  [N_ELEM][Q_BITS+1];
    logic                  r_ovld;
    t_mat                  r_quo;
    logic                  r_ovf;
    t_mat                  n_quo;
    logic [N_ELEM-1:0]     n_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[Q_BITS-1:0], i_valid};
            r_ovld <= r_vld[Q_BITS];
        end
    end

    always_comb begin
        for (int l = 0; l < N_ELEM; l++) begin
            w_t[l][0]  = '0;
            w_ge[l][0] = 1'b0;
            for (int s = 1; s <= Q_BITS; s++) begin
                w_t[l][s]  = {r_rem[l][s-1], r_low[l][s-1][Q_BITS-1]};
                w_ge[l][s] = w_t[l][s] >= {1'b0, r_den[s-1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_den[0] <= i_den;
        r_neg[0] <= i_neg;
        for (int l = 0; l < N_ELEM; l++) begin
            r_pre[0][l] <= (i_num[l] >> Q_BITS) >= i_den;
            r_rem[l][0] <= DET_W'(i_num[l] >> Q_BITS);
            r_low[l][0] <= i_num[l][Q_BITS-1:0];
            r_q[l][0]   <= '0;
        end
        for (int s = 1; s <= Q_BITS; s++) begin
            r_den[s] <= r_den[s-1];
            r_pre[s] <= r_pre[s-1];
            r_neg[s] <= r_neg[s-1];
            for (int l = 0; l < N_ELEM; l++) begin
                r_rem[l][s] <= w_ge[l][s] ? DET_W'(w_t[l][s] - {1'b0, r_den[s-1]})
                                          : w_t[l][s][DET_W-1:0];
                r_low[l][s] <= {r_low[l][s-1][Q_BITS-2:0], 1'b0};
                r_q[l][s]   <= {r_q[l][s-1][Q_BITS-2:0], w_ge[l][s]};
            end
        end
    end

    // saturate and apply sign
    always_comb begin
        for (int l = 0; l < N_ELEM; l++) begin
            if (r_neg[Q_BITS][l]) begin
                n_ovl[l] = r_pre[Q_BITS][l] || (r_q[l][Q_BITS] > NEG_LIM);
                n_quo[l] = n_ovl[l] ? SAT_NEG
                                    : t_elem'(-r_q[l][Q_BITS][ELEM_W-1:0]);
            end else begin
                n_ovl[l] = r_pre[Q_BITS][l] || (r_q[l][Q_BITS] > POS_LIM);
                n_quo[l] = n_ovl[l] ? SAT_POS : t_elem'(r_q[l][Q_BITS][ELEM_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_ovf <= |n_ovl;
    end

    assign o_valid = r_ovld;
    assign o_quo   = r_quo;
    assign o_ovf   = r_ovf;

endmodule

[hdl/matrix3_inverse.sv]
// 3x3 matrix inverse (adjugate over determinant), signed fixed point.
// Depends on m3inv_pkg, m3inv_div and matrix3_inverse_assert.svh.
//
// Usage: drive the nine elements with start high; a word is taken at every
// clock edge with start high, busy is always low, so one matrix per cycle.
// Each result word appears on the o_ ports for one cycle with o_valid high;
// results keep start order.
// Pipeline: 8 front stages (input register, 18 multipliers, cofactors,
// split determinant products, sums, magnitude, threshold compare), 35
// divider stages (pre-check, one quotient bit per stage for 33 bits,
// saturation), one output register. The 33 quotient-bit stages of the
// pipelined divider set the depth.
// Config: i_cfg_we writes the 31-bit zero threshold; write it when no word
// is in flight. Singular words return the input matrix with o_singular set.
// Reset (synchronous, active low) drops all words in flight and clears the
// threshold to zero. The receiver has no back-pressure: o_valid is a strobe.
`include "matrix3_inverse_assert.svh"
module matrix3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [30:0]                i_cfg_data,
    input  m3inv_pkg::t_elem           i_a_r0c0,
    input  m3inv_pkg::t_elem           i_a_r0c1,
    input  m3inv_pkg::t_elem           i_a_r0c2,
    input  m3inv_pkg::t_elem           i_a_r1c0,
    input  m3inv_pkg::t_elem           i_a_r1c1,
    input  m3inv_pkg::t_elem           i_a_r1c2,
    input  m3inv_pkg::t_elem           i_a_r2c0,
    input  m3inv_pkg::t_elem           i_a_r2c1,
    input  m3inv_pkg::t_elem           i_a_r2c2,
    output logic                       o_valid,
    output m3inv_pkg::t_elem           o_inv_r0c0,
    output m3inv_pkg::t_elem           o_inv_r0c1,
    output m3inv_pkg::t_elem           o_inv_r0c2,
    output m3inv_pkg::t_elem           o_inv_r1c0,
    output m3inv_pkg::t_elem           o_inv_r1c1,
    output m3inv_pkg::t_elem           o_inv_r1c2,
    output m3inv_pkg::t_elem           o_inv_r2c0,
    output m3inv_pkg::t_elem           o_inv_r2c1,
    output m3inv_pkg::t_elem           o_inv_r2c2,
    output logic                       o_singular,
    output logic                       o_overflow
);
    import m3inv_pkg::*;

    localparam int SHIFT_W = 2 * FRAC_BITS;
    localparam int NUM_W   = COF_W + SHIFT_W;
    localparam int OUT_LAT = 8 + DIV_LAT + 1;

    t_mat                  w_in;
    logic [THR_W-1:0]      r_thr;
    logic [8:1]            r_vld;
    t_mat                  r_a [1:8];
    logic signed [63:0]    r_pa [N_ELEM];
    logic signed [63:0]    r_pb [N_ELEM];
    t_cof                  r_cof [3:7][N_ELEM];
    t_pp                   r_plo [3];
    t_pp                   r_phi [3];
    t_pj                   r_pj [3];
    t_det                  r_det;
    logic                  r_dneg;
    logic [DET_W-1:0]      r_dmag;
    logic                  r_sing8;
    logic [DET_W-1:0]      r_den8;
    logic [NUM_W-1:0]      r_num8 [N_ELEM];
    logic [N_ELEM-1:0]     r_neg8;
    logic [COF_W-1:0]      w_cmag [N_ELEM];
    t_mat                  r_pass [DIV_LAT];
    logic [DIV_LAT-1:0]    r_sing;
    logic                  w_dvld;
    t_mat                  w_quo;
    logic                  w_qovf;
    logic                  r_ovld;
    t_mat                  r_out;
    logic                  r_osing;
    logic                  r_oovf;

    assign w_in[0] = i_a_r0c0;
    assign w_in[1] = i_a_r0c1;
    assign w_in[2] = i_a_r0c2;
    assign w_in[3] = i_a_r1c0;
    assign w_in[4] = i_a_r1c1;
    assign w_in[5] = i_a_r1c2;
    assign w_in[6] = i_a_r2c0;
    assign w_in[7] = i_a_r2c1;
    assign w_in[8] = i_a_r2c2;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r_vld  <= {r_vld[7:1], start && !busy};
            r_ovld <= w_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[1] <= w_in;
        for (int s = 2; s <= 8; s++) begin
            r_a[s] <= r_a[s-1];
        end
    end

    // minor products: cof[i][j] = a[i+1][j+1]*a[i+2][j+2] - a[i+1][j+2]*a[i+2][j+1]
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam int R1 = (i + 1) % 3;
            localparam int R2 = (i + 2) % 3;
            localparam int C1 = (j + 1) % 3;
            localparam int C2 = (j + 2) % 3;
            always_ff @(posedge i_clk) begin
                r_pa[i*3+j] <= r_a[1][R1*3+C1] * r_a[1][R2*3+C2];
                r_pb[i*3+j] <= r_a[1][R1*3+C2] * r_a[1][R2*3+C1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_ELEM; k++) begin
            r_cof[3][k] <= t_cof'(r_pa[k]) - t_cof'(r_pb[k]);
        end
        for (int s = 4; s <= 7; s++) begin
            r_cof[s] <= r_cof[s-1];
        end
        // row-0 expansion, each cofactor split at bit 32
        for (int j = 0; j < 3; j++) begin
            r_plo[j] <= $signed({1'b0, r_cof[3][j][31:0]}) * r_a[3][j];
            r_phi[j] <= $signed(r_cof[3][j][COF_W-1:32]) * r_a[3][j];
            r_pj[j]  <= (t_pj'(r_phi[j]) <<< 32) + t_pj'(r_plo[j]);
        end
        r_det  <= t_det'(r_pj[0]) + t_det'(r_pj[1]) + t_det'(r_pj[2]);
        r_dneg <= r_det[DET_W-1];
        r_dmag <= r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
    end

    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            w_cmag[k] = r_cof[7][k][COF_W-1] ? COF_W'(-r_cof[7][k]) : COF_W'(r_cof[7][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sing8 <= r_dmag <= {r_thr, {SHIFT_W{1'b0}}};
        r_den8  <= r_dmag;
        for (int k = 0; k < N_ELEM; k++) begin
            r_num8[k] <= {w_cmag[k], {SHIFT_W{1'b0}}};
            r_neg8[k] <= r_cof[7][k][COF_W-1] ^ r_dneg;
        end
    end

    // adjugate is the transposed cofactor matrix
    logic [NUM_W-1:0]  w_dnum [N_ELEM];
    logic [N_ELEM-1:0] w_dneg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_dnum[i*3+j] = r_num8[j*3+i];
                w_dneg[i*3+j] = r_neg8[j*3+i];
            end
        end
    end

    m3inv_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[8]),
        .i_num   (w_dnum),
        .i_neg   (w_dneg),
        .i_den   (r_den8),
        .o_valid (w_dvld),
        .o_quo   (w_quo),
        .o_ovf   (w_qovf)
    );

    always_ff @(posedge i_clk) begin
        r_pass[0] <= r_a[8];
        r_sing    <= {r_sing[DIV_LAT-2:0], r_sing8};
        for (int s = 1; s < DIV_LAT; s++) begin
            r_pass[s] <= r_pass[s-1];
        end
        r_out   <= r_sing[DIV_LAT-1] ? r_pass[DIV_LAT-1] : w_quo;
        r_osing <= r_sing[DIV_LAT-1];
        r_oovf  <= !r_sing[DIV_LAT-1] && w_qovf;
    end

    assign o_valid    = r_ovld;
    assign o_inv_r0c0 = r_out[0];
    assign o_inv_r0c1 = r_out[1];
    assign o_inv_r0c2 = r_out[2];
    assign o_inv_r1c0 = r_out[3];
    assign o_inv_r1c1 = r_out[4];
    assign o_inv_r1c2 = r_out[5];
    assign o_inv_r2c0 = r_out[6];
    assign o_inv_r2c1 = r_out[7];
    assign o_inv_r2c2 = r_out[8];
    assign o_singular = r_osing;
    assign o_overflow = r_oovf;

    `M3INV_ASSERT_NXT(a_take, i_clk, i_rst_n, start && !busy, r_vld[1])
    `M3INV_ASSERT_IMP(a_div_lat, i_clk, i_rst_n, w_dvld, $past(r_vld[8], DIV_LAT))
    `M3INV_ASSERT_IMP(a_out_lat, i_clk, i_rst_n, o_valid, $past(start, OUT_LAT))
    `M3INV_ASSERT_IMP(a_flags, i_clk, i_rst_n, o_valid && o_singular, !o_overflow)

endmodule

[tb/tb_top.sv]
// Self-checking testbench for matrix3_inverse: 3x3 fixed-point inverse via adjugate.
// Depends on m3inv_pkg and the matrix3_inverse RTL; predicts each word in-bench.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import m3inv_pkg::*;

    localparam int FRAC   = 16;
    localparam int LAT    = 44;
    localparam longint LIMIT = 400000;

    typedef struct {
        t_elem m [9];
        logic  sing;
        logic  ovf;
    } inv_word_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic i_cfg_we = 0;
    logic [30:0] i_cfg_data = '0;
    t_elem a [9];
    logic o_valid, o_singular, o_overflow;
    t_elem q [9];

    string inv_names [9] = '{"inv_r0c0", "inv_r0c1", "inv_r0c2",
                             "inv_r1c0", "inv_r1c1", "inv_r1c2",
                             "inv_r2c0", "inv_r2c1", "inv_r2c2"};

    logic [30:0] thr_cur = '0;
    inv_word_t inv_expected [$];
    int send_idle_pct = 0;
    int errors = 0;
    longint cycles = 0;

    initial for (int k = 0; k < 9; k++) a[k] = '0;

    matrix3_inverse dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_a_r0c0(a[0]), .i_a_r0c1(a[1]), .i_a_r0c2(a[2]),
        .i_a_r1c0(a[3]), .i_a_r1c1(a[4]), .i_a_r1c2(a[5]),
        .i_a_r2c0(a[6]), .i_a_r2c1(a[7]), .i_a_r2c2(a[8]),
        .o_valid(o_valid),
        .o_inv_r0c0(q[0]), .o_inv_r0c1(q[1]), .o_inv_r0c2(q[2]),
        .o_inv_r1c0(q[3]), .o_inv_r1c1(q[4]), .o_inv_r1c2(q[5]),
        .o_inv_r2c0(q[6]), .o_inv_r2c1(q[7]), .o_inv_r2c2(q[8]),
        .o_singular(o_singular), .o_overflow(o_overflow)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("matrix3_inverse test failed");
            $finish;
        end
    end

    function automatic inv_word_t compute_inverse(t_elem m [9], logic [30:0] thr);
        inv_word_t r;
        logic signed [127:0] e [3][3];
        logic signed [127:0] cof [3][3];
        logic signed [127:0] det, dmag, c, quo;
        logic [127:0] lim;
        logic neg;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) e[i][j] = m[i*3+j];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = e[(i+1)%3][(j+1)%3] * e[(i+2)%3][(j+2)%3]
                          - e[(i+1)%3][(j+2)%3] * e[(i+2)%3][(j+1)%3];
        det = 0;
        for (int j = 0; j < 3; j++) det += cof[0][j] * e[0][j];
        dmag = det < 0 ? -det : det;
        lim = 128'(thr) << (2*FRAC);
        r.ovf = 0;
        if ($unsigned(dmag) <= lim) begin
            r.m = m;
            r.sing = 1;
            return r;
        end
        r.sing = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                c = cof[j][i];
                neg = (c < 0) != (det < 0);
                if (c < 0) c = -c;
                quo = $signed($unsigned(c << (2*FRAC)) / $unsigned(dmag));
                if (quo > (neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF)) begin
                    r.ovf = 1;
                    r.m[i*3+j] = neg ? SAT_NEG : SAT_POS;
                end else begin
                    r.m[i*3+j] = neg ? t_elem'(-quo) : t_elem'(quo);
                end
            end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        inv_word_t x;
        if (i_rst_n && o_valid) begin
            if (inv_expected.size() == 0) begin
                $error("unexpected word");
                errors++;
            end else begin
                x = inv_expected.pop_front();
                for (int k = 0; k < 9; k++)
                    if (q[k] !== x.m[k]) begin
                        $error("%s expected %h actual %h", inv_names[k], x.m[k], q[k]);
                        errors++;
                    end
                if (o_singular !== x.sing) begin
                    $error("singular expected %b actual %b", x.sing, o_singular);
                    errors++;
                end
                if (o_overflow !== x.ovf) begin
                    $error("overflow expected %b actual %b", x.ovf, o_overflow);
                    errors++;
                end
            end
        end
    end

    // start stays high after a word so back-to-back words need no gap
    task automatic send_matrix(t_elem m [9]);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        for (int k = 0; k < 9; k++) a[k] <= m[k];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        inv_expected.push_back(compute_inverse(m, thr_cur));
    endtask

    task automatic drain();
        start <= 0;
        while (inv_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [30:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        thr_cur = v;
    endtask

    function automatic t_elem rand_elem();
        case ($urandom_range(5))
            0: return t_elem'($urandom);
            1: return t_elem'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
            2: return $urandom_range(1) ? SAT_POS : SAT_NEG;
            3: return t_elem'($signed($urandom_range(0, 512)) - 256);
            default: return t_elem'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic test_directed();
        t_elem m [9];
        // identity, scaled identity, zero, all-extreme, rank-deficient, tridiagonal, permutation
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? t_elem'(1 << FRAC) : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? t_elem'(2 << FRAC) : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? t_elem'(1) : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? SAT_NEG : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = SAT_POS;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = SAT_NEG;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? SAT_POS : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? SAT_NEG : t_elem'(-1);
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = t_elem'((k + 1) << FRAC);
        send_matrix(m);
        m = '{t_elem'(2<<FRAC), t_elem'(-1<<FRAC), 0, t_elem'(-1<<FRAC), t_elem'(2<<FRAC),
              t_elem'(-1<<FRAC), 0, t_elem'(-1<<FRAC), t_elem'(2<<FRAC)};
        send_matrix(m);
        m = '{0, t_elem'(1<<FRAC), 0, 0, 0, t_elem'(-1<<FRAC), t_elem'(1<<FRAC), 0, 0};
        send_matrix(m);
    endtask

    task automatic test_random(int n);
        t_elem m [9];
        repeat (n) begin
            for (int k = 0; k < 9; k++) m[k] = rand_elem();
            if ($urandom_range(9) == 0) m[3 + $urandom_range(2)] = m[$urandom_range(2)];
            send_matrix(m);
        end
    endtask

    task automatic test_thresholds();
        write_threshold(31'h7FFF_FFFF);
        test_directed();
        test_random(100);
        write_threshold(31'h0000_0001);
        test_random(100);
        write_threshold(31'h0001_0000);
        test_random(150);
        write_threshold(31'h2AAA_5555);
        test_random(50);
        write_threshold('0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_idle_pct = 32;
        test_directed();
        test_random(500);
        test_thresholds();
        send_idle_pct = 60;
        test_random(300);
        send_idle_pct = 0;
        test_random(500);
        drain();
        repeat (LAT) @(posedge i_clk);
        if (errors == 0 && inv_expected.size() == 0) begin
            $display("matrix3_inverse test passed");
        end else begin
            $display("matrix3_inverse test failed");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/m3inv_pkg.sv
hdl/m3inv_div.sv
hdl/matrix3_inverse.sv
tb/tb_top.sv
